@@ rtl/dqts_pkg.sv @@
// ----------------------------------------------------------------------------
// dqts_pkg
// Shared types and constants of the delta-list timer task queue.
// ----------------------------------------------------------------------------
package dqts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int DELAY_BITS = 24;
    localparam int SLOT_BITS  = $clog2(MAX_TASKS);
    localparam int CNT_BITS   = $clog2(MAX_TASKS + 1);
    localparam int ID_BITS    = 16;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ADD      = 2'd1;
    localparam logic [1:0] CMD_DELETE   = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    // One memory word: delta, period, id, link.
    localparam int ENTRY_BITS = 2 * DELAY_BITS + ID_BITS + SLOT_BITS;

    typedef struct packed {
        logic [DELAY_BITS-1:0] delta;
        logic [DELAY_BITS-1:0] period;
        logic [ID_BITS-1:0]    ident;
        logic [SLOT_BITS-1:0]  link;
    } t_entry;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [DELAY_BITS-1:0] delay_ticks;
        logic [DELAY_BITS-1:0] period_ticks;
        logic [ID_BITS-1:0]    target_id;
    } t_in;

    typedef struct packed {
        logic               done_res;
        logic [ID_BITS-1:0] task_id;
        logic [1:0]         error_code;
    } t_out;

endpackage

@@ rtl/dqts_ram.sv @@
// ----------------------------------------------------------------------------
// dqts_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dqts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/delta_queue_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// delta_queue_task_scheduler_unit
// Timer task queue kept as a delta list in one entry RAM.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  input   | in        | i_valid, o_ready, i_data (dqts_pkg::t_in)
//  output  | out       | o_valid, i_ready, o_data (dqts_pkg::t_out)
//
//  A transaction is walked by a sequencer around the single-port entry RAM;
//  each list step is an address state followed by a read-data state.
//  Ticks and plain dispatches touch only the head entry; adds, deletes and
//  periodic dispatches may walk the list. Synchronous active-low reset
//  empties the queue; no clearing pass runs. A waiting result holds off
//  the input until it is taken.
// ----------------------------------------------------------------------------
module delta_queue_task_scheduler_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dqts_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output dqts_pkg::t_out    o_data
);

    localparam int SB = dqts_pkg::SLOT_BITS;
    localparam int DB = dqts_pkg::DELAY_BITS;
    localparam int CB = dqts_pkg::CNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD_RD, S_HEAD_WAIT, S_HEAD_USE, S_WALK_RD, S_WALK_USE,
        S_FIX_RD, S_FIX_WAIT, S_FIX_WR, S_NEW_WR, S_RESULT
    } t_state;

    t_state                       r_state;
    dqts_pkg::t_in                r_in;
    logic [dqts_pkg::MAX_TASKS-1:0] r_used;
    logic [SB-1:0]                r_head;
    logic [CB-1:0]                r_len;
    logic [DB-1:0]                r_skip;
    logic [dqts_pkg::ID_BITS-1:0] r_idc;
    // walk state
    logic [SB-1:0]                r_cur, r_prev, r_slot;
    logic                         r_has_prev;
    logic [CB-1:0]                r_idx, r_n;
    logic [DB:0]                  r_sum;
    logic [DB-1:0]                r_d;
    logic [DB-1:0]                r_fix_delta;   // delta to add/sub at fix
    logic                         r_fix_sub;
    logic [SB-1:0]                r_fix_slot;
    logic [SB-1:0]                r_fix_link;
    logic                         r_fix_link_en;
    logic                         r_fix_delta_en;
    dqts_pkg::t_entry             r_new;
    logic                         r_new_pending;
    dqts_pkg::t_out               r_res;
    logic                         r_ovalid;

    // RAM port
    logic                         w_we;
    logic [SB-1:0]                w_addr;
    dqts_pkg::t_entry             w_wdata, w_rdata;

    dqts_ram #(.WIDTH(dqts_pkg::ENTRY_BITS), .DEPTH(dqts_pkg::MAX_TASKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // free slot search
    logic [SB-1:0] w_free;
    always_comb begin
        w_free = '0;
        for (int k = dqts_pkg::MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_free = SB'(k);
            end
        end
    end

    logic [DB:0]   w_sum_next;
    logic [DB:0]   w_add_sum;
    logic [DB-1:0] w_skip_inc;
    assign w_sum_next = r_sum + {1'b0, w_rdata.delta};
    assign w_add_sum  = {1'b0, r_in.delay_ticks} + {1'b0, r_skip};
    assign w_skip_inc = (r_skip != dqts_pkg::DELAY_MAX) ? r_skip + 1'b1 : r_skip;

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_cur;
        w_wdata = w_rdata;
        case (r_state)
            S_HEAD_RD, S_HEAD_WAIT, S_WALK_RD: w_addr = r_cur;
            S_HEAD_USE: begin
                w_addr = r_cur;
                if (r_in.cmd == dqts_pkg::CMD_TICK && w_rdata.delta != '0) begin
                    w_we = 1'b1;
                    w_wdata.delta = (w_rdata.delta >= w_skip_inc) ?
                                    w_rdata.delta - w_skip_inc : '0;
                end
            end
            S_FIX_RD, S_FIX_WAIT: w_addr = r_fix_slot;
            S_FIX_WR: begin
                w_addr = r_fix_slot;
                w_we   = 1'b1;
                // a link fix never carries a delta; any delta fix runs as its own pass
                if (r_fix_delta_en && !r_fix_link_en) begin
                    w_wdata.delta = r_fix_sub ? w_rdata.delta - r_fix_delta
                                              : w_rdata.delta + r_fix_delta;
                end
                if (r_fix_link_en) begin
                    w_wdata.link = r_fix_link;
                end
            end
            S_NEW_WR: begin
                w_addr  = r_slot;
                w_we    = 1'b1;
                w_wdata = r_new;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !(r_ovalid && !i_ready);
    assign o_valid = r_ovalid;
    assign o_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_head   <= '0;
            r_len    <= '0;
            r_skip   <= '0;
            r_idc    <= dqts_pkg::ID_BITS'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in           <= i_data;
                        r_cur          <= r_head;
                        r_res          <= '0;
                        r_fix_delta_en <= 1'b0;
                        r_fix_link_en  <= 1'b0;
                        r_new_pending  <= 1'b0;
                        r_has_prev     <= 1'b0;
                        r_idx          <= '0;
                        r_sum          <= '0;
                        r_state        <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: begin
                    r_state <= S_HEAD_WAIT;
                    case (r_in.cmd)
                        dqts_pkg::CMD_TICK: begin
                            if (r_len == '0) begin
                                r_skip  <= '0;
                                r_state <= S_RESULT;
                            end
                        end
                        dqts_pkg::CMD_ADD: begin
                            if (r_len == CB'(dqts_pkg::MAX_TASKS)) begin
                                r_res.error_code <= dqts_pkg::ERR_FULL;
                                r_state <= S_RESULT;
                            end else begin
                                r_slot <= w_free;
                                r_d    <= w_add_sum[DB] ? dqts_pkg::DELAY_MAX
                                                        : w_add_sum[DB-1:0];
                                r_n    <= r_len;
                                r_new.period <= r_in.period_ticks;
                                r_new.ident  <= r_idc;
                                r_res.done_res <= 1'b1;
                                r_res.task_id  <= r_idc;
                                r_idc <= (r_idc == '1) ? dqts_pkg::ID_BITS'(1)
                                                       : r_idc + 1'b1;
                                r_used[w_free] <= 1'b1;
                                r_len <= r_len + 1'b1;
                                r_state <= S_WALK_RD;
                                if (r_len == '0) begin
                                    r_head <= w_free;
                                    r_new.delta <= w_add_sum[DB] ?
                                        dqts_pkg::DELAY_MAX : w_add_sum[DB-1:0];
                                    r_new.link <= '0;
                                    r_state <= S_NEW_WR;
                                end
                            end
                        end
                        dqts_pkg::CMD_DELETE: begin
                            if (r_len == '0) begin
                                r_res.error_code <= dqts_pkg::ERR_NOT_FOUND;
                                r_state <= S_RESULT;
                            end else begin
                                r_state <= S_WALK_RD;
                            end
                        end
                        default: begin
                            if (r_len == '0) r_state <= S_RESULT;
                        end
                    endcase
                end
                S_HEAD_WAIT: r_state <= S_HEAD_USE;
                S_HEAD_USE: begin
                    r_state <= S_RESULT;
                    if (r_in.cmd == dqts_pkg::CMD_TICK) begin
                        if (w_rdata.delta == '0) begin
                            r_skip <= w_skip_inc;
                        end else if (w_rdata.delta >= w_skip_inc) begin
                            r_skip <= '0;
                        end else begin
                            r_skip <= w_skip_inc - w_rdata.delta;
                        end
                    end else if (w_rdata.delta == '0) begin
                        // dispatch a due head
                        r_res.done_res <= 1'b1;
                        r_res.task_id  <= w_rdata.ident;
                        r_head <= (r_len > CB'(1)) ? w_rdata.link : '0;
                        if (w_rdata.period != '0) begin
                            r_slot <= r_cur;
                            r_d    <= w_rdata.period;
                            r_n    <= r_len - 1'b1;
                            r_new  <= w_rdata;
                            r_cur  <= w_rdata.link;
                            if (r_len == CB'(1)) begin
                                r_head <= r_cur;
                                r_new.delta <= w_rdata.period;
                                r_new.link  <= '0;
                                r_state <= S_NEW_WR;
                            end else begin
                                r_state <= S_WALK_RD;
                            end
                        end else begin
                            r_used[r_cur] <= 1'b0;
                            r_len <= r_len - 1'b1;
                        end
                    end
                end
                S_WALK_RD: r_state <= S_WALK_USE;
                S_WALK_USE: begin
                    if (r_in.cmd == dqts_pkg::CMD_DELETE) begin
                        if (w_rdata.ident == r_in.target_id) begin
                            r_res.done_res <= 1'b1;
                            r_res.task_id  <= r_in.target_id;
                            r_used[r_cur] <= 1'b0;
                            r_len <= r_len - 1'b1;
                            if (r_len == CB'(1)) begin
                                r_head <= '0;
                            end else if (!r_has_prev) begin
                                r_head <= w_rdata.link;
                            end
                            r_fix_link_en  <= r_has_prev;
                            r_fix_link     <= w_rdata.link;
                            r_fix_slot     <= r_prev;
                            r_fix_delta_en <= (r_idx + 1'b1 < r_len);
                            r_fix_delta    <= w_rdata.delta;
                            r_fix_sub      <= 1'b0;
                            r_slot         <= w_rdata.link;
                            r_state <= r_has_prev ? S_FIX_RD : S_RESULT;
                            if (r_idx + 1'b1 < r_len && !r_has_prev) begin
                                r_fix_slot <= w_rdata.link;
                                r_fix_link_en <= 1'b0;
                                r_state <= S_FIX_RD;
                            end
                        end else if (r_idx + 1'b1 == r_len) begin
                            r_res.error_code <= dqts_pkg::ERR_NOT_FOUND;
                            r_state <= S_RESULT;
                        end else begin
                            r_prev <= r_cur;
                            r_has_prev <= 1'b1;
                            r_cur <= w_rdata.link;
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_WALK_RD;
                        end
                    end else begin
                        // insert walk (add or periodic reinsertion)
                        if (w_sum_next > {1'b0, r_d}) begin
                            r_new.delta <= r_d - r_sum[DB-1:0];
                            r_new.link  <= r_cur;
                            r_fix_slot     <= r_cur;
                            r_fix_delta_en <= 1'b1;
                            r_fix_delta    <= r_d - r_sum[DB-1:0];
                            r_fix_sub      <= 1'b1;
                            r_fix_link_en  <= 1'b0;
                            r_new_pending  <= 1'b1;
                            if (!r_has_prev) r_head <= r_slot;
                            r_state <= S_FIX_RD;
                        end else if (r_idx + 1'b1 == r_n) begin
                            r_new.delta <= r_d - w_sum_next[DB-1:0];
                            r_new.link  <= '0;
                            r_fix_slot    <= r_cur;
                            r_fix_link    <= r_slot;
                            r_fix_link_en <= 1'b1;
                            r_new_pending <= 1'b1;
                            r_state <= S_FIX_RD;
                        end else begin
                            r_sum <= w_sum_next;
                            r_prev <= r_cur;
                            r_has_prev <= 1'b1;
                            r_cur <= w_rdata.link;
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_FIX_RD: r_state <= S_FIX_WAIT;
                S_FIX_WAIT: r_state <= S_FIX_WR;
                S_FIX_WR: begin
                    // a delete with predecessor also fixes the successor delta
                    if (r_in.cmd == dqts_pkg::CMD_DELETE && r_fix_link_en &&
                        r_fix_delta_en) begin
                        r_fix_link_en <= 1'b0;
                        r_fix_slot <= r_slot;
                        r_state <= S_FIX_RD;
                    end else if (r_new_pending && r_has_prev &&
                                 !r_fix_link_en) begin
                        // link predecessor to the new entry
                        r_fix_delta_en <= 1'b0;
                        r_fix_link_en  <= 1'b1;
                        r_fix_link     <= r_slot;
                        r_fix_slot     <= r_prev;
                        r_has_prev     <= 1'b0;
                        r_state <= S_FIX_RD;
                    end else begin
                        r_state <= r_new_pending ? S_NEW_WR : S_RESULT;
                    end
                end
                S_NEW_WR: r_state <= S_RESULT;
                S_RESULT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
